FILE: src/tlge_pkg.sv
// Shared types and constants of the toroidal Life grid engine.
`timescale 1ns / 1ps

package tlge_pkg;

   // Payload widths of the request and response channels.
   localparam int CMD_W = 2;
   localparam int ROW_W = 5;
   localparam int COL_W = 5;
   localparam int GEN_W = 20;

   // Configuration port widths.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'd1;

   // Size register value after reset, and the smallest used size.
   localparam logic [CSR_DATA_W-1:0] SIZE_RESET = 6'd30;
   localparam int SIZE_MIN = 3;

   // Control broadcast from the sequencer to every row cell.
   typedef struct packed {
      logic             step;
      logic             wr_en;
      logic [ROW_W-1:0] wr_row;
      logic [COL_W-1:0] wr_col;
      logic             wr_val;
   } grid_ctrl_type;

   // Address of the cell that the sequencer looks at.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } rd_addr_type;

   // Value of that cell and whether it lies inside the used grid.
   typedef struct packed {
      logic bit_val;
      logic in_grid;
   } rd_data_type;

endpackage

FILE: src/tlge_req_if.sv
// Request channel interface of the Life grid engine.
`timescale 1ns / 1ps

interface tlge_req_if;
   logic                       valid;
   logic                       ready;
   logic [tlge_pkg::CMD_W-1:0] cmd;
   logic [tlge_pkg::ROW_W-1:0] row;
   logic [tlge_pkg::COL_W-1:0] col;
   logic                       cell_in;
   logic [tlge_pkg::GEN_W-1:0] generations;

   modport source (output valid, cmd, row, col, cell_in, generations, input ready);
   modport sink (input valid, cmd, row, col, cell_in, generations, output ready);
endinterface

FILE: src/tlge_rsp_if.sv
// Response channel interface of the Life grid engine.
`timescale 1ns / 1ps

interface tlge_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       cell_out;
   logic [tlge_pkg::CMD_W-1:0] cmd_echo;

   modport source (output valid, cell_out, cmd_echo, input ready);
   modport sink (input valid, cell_out, cmd_echo, output ready);
endinterface

FILE: src/toroidal_life_grid_engine_unit.sv
// Top level of the toroidal Life grid engine: size registers, row cell chain, sequencer.
// A write, read or zero-length run is answered in the cycle after acceptance.
// A run advances the row cell chain one generation a cycle, then answers once the slot is free.
// Throughput: one write or read per cycle if not running and the response slot is free.
// Reset: synchronous, clears every cell to dead and sets both sizes to 30 (clamped).
`timescale 1ns / 1ps

module toroidal_life_grid_engine_unit #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   tlge_req_if.sink                        req_ch,
   tlge_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [tlge_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlge_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   localparam int RIW = $clog2(MAX_ROWS);
   localparam int CIW = $clog2(MAX_COLS);

   // Used size minus one, clamped to the supported range.
   function automatic int size_m1(logic [tlge_pkg::CSR_DATA_W-1:0] v, int maxv);
      int s;
      s = int'(v);
      if (s < tlge_pkg::SIZE_MIN) begin
         s = tlge_pkg::SIZE_MIN;
      end
      if (s > maxv) begin
         s = maxv;
      end
      return s - 1;
   endfunction

   logic [RIW-1:0] nrm1_ff, nrm1_in;
   logic [CIW-1:0] ncm1_ff, ncm1_in;

   tlge_pkg::grid_ctrl_type ctrl;
   tlge_pkg::rd_addr_type   rd_addr;
   tlge_pkg::rd_data_type   rd_data;

   logic [MAX_COLS-1:0] row_q [MAX_ROWS];
   logic [MAX_COLS-1:0] rd_row_bits;

   // Size registers hold the clamped size minus one.
   always_comb begin
      nrm1_in = nrm1_ff;
      ncm1_in = ncm1_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tlge_pkg::CSR_GRID_ROWS: nrm1_in = RIW'(size_m1(csr_wr_data, MAX_ROWS));
            tlge_pkg::CSR_GRID_COLS: ncm1_in = CIW'(size_m1(csr_wr_data, MAX_COLS));
            default: begin
               nrm1_in = nrm1_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nrm1_ff <= RIW'(size_m1(tlge_pkg::SIZE_RESET, MAX_ROWS));
         ncm1_ff <= CIW'(size_m1(tlge_pkg::SIZE_RESET, MAX_COLS));
      end else begin
         nrm1_ff <= nrm1_in;
         ncm1_ff <= ncm1_in;
      end
   end

   // Chain of row cells; each hands its row to the rows above and below.
   for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
      logic [MAX_COLS-1:0] up_row;
      logic [MAX_COLS-1:0] dn_row;
      logic                active;

      if (r == 0) begin : g_up_wrap
         assign up_row = row_q[nrm1_ff];
      end else begin : g_up
         assign up_row = row_q[r-1];
      end

      if (r == MAX_ROWS - 1) begin : g_dn_wrap
         assign dn_row = row_q[0];
      end else begin : g_dn
         assign dn_row = (RIW'(r) == nrm1_ff) ? row_q[0] : row_q[r+1];
      end

      assign active = (RIW'(r) <= nrm1_ff);

      tlge_row_cell #(
         .MAX_COLS (MAX_COLS),
         .ROW_IDX  (r),
         .CIW      (CIW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .active (active),
         .ncm1   (ncm1_ff),
         .up_row (up_row),
         .dn_row (dn_row),
         .row_q  (row_q[r])
      );
   end

   // Read of the addressed cell and the bounds check.
   always_comb begin
      rd_row_bits     = '0;
      rd_data.bit_val = 1'b0;
      for (int r = 0; r < MAX_ROWS; r++) begin
         if (int'(rd_addr.row) == r) begin
            rd_row_bits = row_q[r];
         end
      end
      for (int c = 0; c < MAX_COLS; c++) begin
         if (int'(rd_addr.col) == c) begin
            rd_data.bit_val = rd_row_bits[c];
         end
      end
      rd_data.in_grid = (int'(rd_addr.row) <= int'(nrm1_ff))
                     && (int'(rd_addr.col) <= int'(ncm1_ff));
   end

   tlge_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .ctrl    (ctrl),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

`ifndef SYNTH
   // A cell write only happens for an accepted request.
   a_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_en |-> (req_ch.valid && req_ch.ready))
      else $error("cell write without an accepted request");

   // A run with a nonzero count starts stepping in the next cycle.
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.cmd == tlge_pkg::CMD_RUN)
       && (req_ch.generations != '0)) |=> ctrl.step)
      else $error("run request did not start stepping");

   // No request is taken while the grid is stepping.
   a_no_accept_in_run: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |-> !req_ch.ready)
      else $error("request accepted while stepping");
`endif

endmodule

FILE: src/tlge_row_cell.sv
// One grid row: holds its cells and computes their next generation.
`timescale 1ns / 1ps

module tlge_row_cell #(
   parameter int MAX_COLS = 32,
   parameter int ROW_IDX  = 0,
   parameter int CIW      = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tlge_pkg::grid_ctrl_type ctrl,
   input  logic                    active,
   input  logic [CIW-1:0]          ncm1,
   input  logic [MAX_COLS-1:0]     up_row,
   input  logic [MAX_COLS-1:0]     dn_row,
   output logic [MAX_COLS-1:0]     row_q
);

   logic [MAX_COLS-1:0] row_ff;
   logic [MAX_COLS-1:0] row_in;
   logic [MAX_COLS-1:0] nxt;
   logic [MAX_COLS-1:0] col_act;

   // Per column: neighbors with wrap at the used column count, then the rule.
   for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
      logic up_l, up_r, me_l, me_r, dn_l, dn_r;
      logic [3:0] live;

      if (c == 0) begin : g_left_wrap
         assign up_l = up_row[ncm1];
         assign me_l = row_ff[ncm1];
         assign dn_l = dn_row[ncm1];
      end else begin : g_left
         assign up_l = up_row[c-1];
         assign me_l = row_ff[c-1];
         assign dn_l = dn_row[c-1];
      end

      if (c == MAX_COLS - 1) begin : g_right_wrap
         assign up_r = up_row[0];
         assign me_r = row_ff[0];
         assign dn_r = dn_row[0];
      end else begin : g_right
         assign up_r = (CIW'(c) == ncm1) ? up_row[0] : up_row[c+1];
         assign me_r = (CIW'(c) == ncm1) ? row_ff[0] : row_ff[c+1];
         assign dn_r = (CIW'(c) == ncm1) ? dn_row[0] : dn_row[c+1];
      end

      assign live = 4'(up_l) + 4'(up_row[c]) + 4'(up_r) + 4'(me_l) + 4'(me_r)
                  + 4'(dn_l) + 4'(dn_row[c]) + 4'(dn_r);

      // Birth on three, survival on two or three.
      assign nxt[c] = (live == 4'd3) || (row_ff[c] && (live == 4'd2));
      assign col_act[c] = (CIW'(c) <= ncm1);
   end

   // Generation step on used cells, or a single-cell write.
   always_comb begin
      row_in = row_ff;
      if (ctrl.step && active) begin
         for (int c = 0; c < MAX_COLS; c++) begin
            if (col_act[c]) begin
               row_in[c] = nxt[c];
            end
         end
      end
      if (ctrl.wr_en && (int'(ctrl.wr_row) == ROW_IDX)) begin
         for (int c = 0; c < MAX_COLS; c++) begin
            if (int'(ctrl.wr_col) == c) begin
               row_in[c] = ctrl.wr_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_q = row_ff;

endmodule

FILE: src/tlge_seq.sv
// Command sequencer: request handshake, generation counter and response register.
`timescale 1ns / 1ps

module tlge_seq (
   input  logic                    clock,
   input  logic                    reset,
   tlge_req_if.sink                req_ch,
   tlge_rsp_if.source              rsp_ch,
   output tlge_pkg::grid_ctrl_type ctrl,
   output tlge_pkg::rd_addr_type   rd_addr,
   input  tlge_pkg::rd_data_type   rd_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [tlge_pkg::GEN_W-1:0] count_ff, count_in;
   logic [tlge_pkg::ROW_W-1:0] row_ff, row_in;
   logic [tlge_pkg::COL_W-1:0] col_ff, col_in;
   logic [tlge_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       cell_out_ff, cell_out_in;
   logic [tlge_pkg::CMD_W-1:0] cmd_echo_ff, cmd_echo_in;

   logic idle;
   logic out_free;
   logic accept;
   logic run_start;
   logic load;

   // A request is taken when idle and the response slot is free or draining.
   assign idle      = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = idle && out_free;
   assign accept    = req_ch.valid && req_ch.ready;
   assign run_start = accept && (req_ch.cmd == tlge_pkg::CMD_RUN) && (req_ch.generations != '0);
   assign load      = (accept && !run_start) || ((state_ff == ST_FIN) && out_free);

   // The looked-at cell is the request's when idle, else the held one.
   assign rd_addr.row = idle ? req_ch.row : row_ff;
   assign rd_addr.col = idle ? req_ch.col : col_ff;

   // Grid control: writes inside the used grid, steps while running.
   assign ctrl.step   = (state_ff == ST_RUN);
   assign ctrl.wr_en  = accept && (req_ch.cmd == tlge_pkg::CMD_WRITE) && rd_data.in_grid;
   assign ctrl.wr_row = req_ch.row;
   assign ctrl.wr_col = req_ch.col;
   assign ctrl.wr_val = req_ch.cell_in;

   // State, counter and held request.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      cmd_in   = cmd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (run_start) begin
               state_in = ST_RUN;
               count_in = req_ch.generations;
               row_in   = req_ch.row;
               col_in   = req_ch.col;
               cmd_in   = req_ch.cmd;
            end
         end
         ST_RUN: begin
            count_in = count_ff - 1'b1;
            if (count_ff == tlge_pkg::GEN_W'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      cell_out_in  = cell_out_ff;
      cmd_echo_in  = cmd_echo_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         cmd_echo_in  = idle ? req_ch.cmd : cmd_ff;
         if (idle && (req_ch.cmd == tlge_pkg::CMD_WRITE)) begin
            cell_out_in = rd_data.in_grid && req_ch.cell_in;
         end else begin
            cell_out_in = rd_data.in_grid && rd_data.bit_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      cmd_ff      <= cmd_in;
      cell_out_ff <= cell_out_in;
      cmd_echo_ff <= cmd_echo_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.cell_out = cell_out_ff;
   assign rsp_ch.cmd_echo = cmd_echo_ff;

endmodule

FILE: bench/tb_top.sv
// Testbench for the toroidal Life grid engine: directed and random commands, grid predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 32;
   localparam int IDLE_LIMIT = 4_500_000;
   localparam int DRAIN_CYCLES = 20;
   // Command code that the block leaves unused.
   localparam logic [tlge_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [tlge_pkg::GEN_W-1:0] GEN_ALL_ONES = '1;

   typedef struct packed {
      logic [tlge_pkg::CMD_W-1:0] cmd;
      logic [tlge_pkg::ROW_W-1:0] row;
      logic [tlge_pkg::COL_W-1:0] col;
      logic                       cell_in;
      logic [tlge_pkg::GEN_W-1:0] generations;
   } life_req_type;

   typedef struct packed {
      logic                       cell_out;
      logic [tlge_pkg::CMD_W-1:0] cmd_echo;
   } life_rsp_type;

   typedef bit [MAX_ROWS-1:0][MAX_COLS-1:0] grid_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_wr_en;
   logic [tlge_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tlge_pkg::CSR_DATA_W-1:0] csr_wr_data;

   tlge_req_if req_bus();
   tlge_rsp_if rsp_bus();

   toroidal_life_grid_engine_unit #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // Predicted grid, size registers and responses still owed by the block.
   grid_type                      life_grid;
   bit [tlge_pkg::CSR_DATA_W-1:0] rows_reg;
   bit [tlge_pkg::CSR_DATA_W-1:0] cols_reg;
   life_rsp_type                  expected_cells[$];
   int                            error_count = 0;
   int                            send_idle_pct = 0;
   int                            rsp_stall_pct = 0;
   int                            idle_cycles = 0;

   always #5 clock = ~clock;

   // Clamp a size register to the range the grid can use.
   function automatic int used_size(bit [tlge_pkg::CSR_DATA_W-1:0] reg_val, int max_size);
      if (reg_val < tlge_pkg::SIZE_MIN) return tlge_pkg::SIZE_MIN;
      if (reg_val > max_size) return max_size;
      return int'(reg_val);
   endfunction

   // One B3/S23 generation over the used part of the torus; other cells keep their values.
   function automatic grid_type advance_generation(grid_type g, int nr, int nc);
      grid_type nxt;
      int r, c, up, dn, lf, rt, live;
      nxt = g;
      for (r = 0; r < nr; r++) begin
         up = (r == 0) ? nr - 1 : r - 1;
         dn = (r + 1 == nr) ? 0 : r + 1;
         for (c = 0; c < nc; c++) begin
            lf = (c == 0) ? nc - 1 : c - 1;
            rt = (c + 1 == nc) ? 0 : c + 1;
            live = g[up][lf] + g[up][c] + g[up][rt] + g[r][lf] + g[r][rt]
                 + g[dn][lf] + g[dn][c] + g[dn][rt];
            if (g[r][c]) begin
               nxt[r][c] = (live == 2) || (live == 3);
            end else begin
               nxt[r][c] = (live == 3);
            end
         end
      end
      return nxt;
   endfunction

   // Advance the grid; a pattern that settles into period one or two ends the loop early.
   function automatic void run_life(int unsigned count, int nr, int nc);
      grid_type    nxt;
      grid_type    prior;
      bit          have_prior;
      int unsigned g;
      int unsigned left;
      have_prior = 1'b0;
      for (g = 0; g < count; g++) begin
         left = count - g - 1;
         nxt = advance_generation(life_grid, nr, nc);
         if (nxt == life_grid) return;
         if (have_prior && nxt == prior) begin
            if (left % 2 == 0) life_grid = nxt;
            return;
         end
         prior = life_grid;
         have_prior = 1'b1;
         life_grid = nxt;
      end
   endfunction

   // Apply one request to the predicted grid and return the response it should give.
   function automatic life_rsp_type predict_cell(life_req_type q);
      life_rsp_type rsp;
      int           nr, nc;
      bit           inside_grid;
      nr = used_size(rows_reg, MAX_ROWS);
      nc = used_size(cols_reg, MAX_COLS);
      inside_grid = (q.row < nr) && (q.col < nc);
      if (q.cmd == tlge_pkg::CMD_WRITE) begin
         if (inside_grid) life_grid[q.row][q.col] = q.cell_in;
      end else if (q.cmd == tlge_pkg::CMD_RUN) begin
         run_life(32'(q.generations), nr, nc);
      end
      rsp.cell_out = inside_grid ? life_grid[q.row][q.col] : 1'b0;
      rsp.cmd_echo = q.cmd;
      return rsp;
   endfunction

   // Check each response, predict each request, and watch for a stuck block.
   always @(posedge clock) begin : monitor
      life_req_type accepted;
      life_rsp_type want;
      bit           moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (expected_cells.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, actual %0d/%0d",
                        $time, rsp_bus.cell_out, rsp_bus.cmd_echo);
            end else begin
               want = expected_cells.pop_front();
               if (rsp_bus.cell_out !== want.cell_out) begin
                  error_count++;
                  $display("%0t: cell_out mismatch, expected %0d actual %0d",
                           $time, want.cell_out, rsp_bus.cell_out);
               end
               if (rsp_bus.cmd_echo !== want.cmd_echo) begin
                  error_count++;
                  $display("%0t: cmd_echo mismatch, expected %0d actual %0d",
                           $time, want.cmd_echo, rsp_bus.cmd_echo);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            accepted.cmd = req_bus.cmd;
            accepted.row = req_bus.row;
            accepted.col = req_bus.col;
            accepted.cell_in = req_bus.cell_in;
            accepted.generations = req_bus.generations;
            expected_cells.push_back(predict_cell(accepted));
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout with %0d responses outstanding", $time, expected_cells.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // The receiver stalls at random at the configured rate.
   always @(negedge clock) begin
      rsp_bus.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   // Present one request, idling before it at the configured rate; returns once accepted.
   task automatic send_cmd(input logic [tlge_pkg::CMD_W-1:0] cmd,
                           input logic [tlge_pkg::ROW_W-1:0] row,
                           input logic [tlge_pkg::COL_W-1:0] col, input logic cell_in,
                           input logic [tlge_pkg::GEN_W-1:0] generations);
      @(negedge clock);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.cmd = cmd;
      req_bus.row = row;
      req_bus.col = col;
      req_bus.cell_in = cell_in;
      req_bus.generations = generations;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stop sending and wait until every owed response has arrived.
   task automatic drain_requests();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
   endtask

   // Write both size registers while the block is idle.
   task automatic set_sizes(input logic [tlge_pkg::CSR_DATA_W-1:0] rows_val,
                            input logic [tlge_pkg::CSR_DATA_W-1:0] cols_val);
      drain_requests();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = tlge_pkg::CSR_GRID_ROWS;
      csr_wr_data = rows_val;
      @(negedge clock);
      csr_index = tlge_pkg::CSR_GRID_COLS;
      csr_wr_data = cols_val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      rows_reg = rows_val;
      cols_reg = cols_val;
   endtask

   // Mostly short runs, some empty ones and a few longer ones.
   function automatic logic [tlge_pkg::GEN_W-1:0] pick_generations();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 90) return tlge_pkg::GEN_W'($urandom_range(1, 12));
      return tlge_pkg::GEN_W'($urandom_range(13, 200));
   endfunction

   // Random traffic: mostly a seeded patch that is run and then read back, the rest noise.
   task automatic run_random_items(input int count);
      int sent, nr, nc, base_r, base_c;
      bit paused;
      sent = 0;
      paused = 1'b0;
      nr = used_size(rows_reg, MAX_ROWS);
      nc = used_size(cols_reg, MAX_COLS);
      while (sent < count) begin
         if ($urandom_range(99) < 70) begin
            base_r = $urandom_range(nr - 1);
            base_c = $urandom_range(nc - 1);
            repeat ($urandom_range(3, 9)) begin
               send_cmd(tlge_pkg::CMD_WRITE,
                        tlge_pkg::ROW_W'((base_r + $urandom_range(3)) % nr),
                        tlge_pkg::COL_W'((base_c + $urandom_range(3)) % nc),
                        $urandom_range(99) < 80, tlge_pkg::GEN_W'($urandom));
               sent++;
            end
            send_cmd(tlge_pkg::CMD_RUN, tlge_pkg::ROW_W'($urandom_range(nr - 1)),
                     tlge_pkg::COL_W'($urandom_range(nc - 1)),
                     1'($urandom_range(1)), pick_generations());
            sent++;
            repeat ($urandom_range(1, 4)) begin
               send_cmd(tlge_pkg::CMD_READ,
                        tlge_pkg::ROW_W'((base_r + $urandom_range(3)) % nr),
                        tlge_pkg::COL_W'((base_c + $urandom_range(3)) % nc),
                        1'($urandom_range(1)), tlge_pkg::GEN_W'($urandom));
               sent++;
            end
         end else begin
            send_cmd(tlge_pkg::CMD_W'($urandom_range(3)), tlge_pkg::ROW_W'($urandom_range(31)),
                     tlge_pkg::COL_W'($urandom_range(31)), 1'($urandom_range(1)),
                     pick_generations());
            sent++;
         end
         // Halfway through, hold off until the block has answered everything.
         if (!paused && sent >= count / 2) begin
            drain_requests();
            paused = 1'b1;
         end
      end
   endtask

   // Edges of the address fields, every command, wrap-around oscillators and the longest run.
   task automatic test_reset_and_edges();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_cmd(tlge_pkg::CMD_READ, 0, 0, 1'b0, '0);
      send_cmd(tlge_pkg::CMD_READ, 31, 31, 1'b1, GEN_ALL_ONES);
      send_cmd(tlge_pkg::CMD_WRITE, 0, 0, 1'b1, '0);
      send_cmd(tlge_pkg::CMD_WRITE, 29, 29, 1'b1, '0);
      send_cmd(tlge_pkg::CMD_WRITE, 31, 31, 1'b1, GEN_ALL_ONES);
      send_cmd(tlge_pkg::CMD_READ, 31, 31, 1'b0, '0);
      send_cmd(tlge_pkg::CMD_READ, 29, 29, 1'b0, '0);
      send_cmd(tlge_pkg::CMD_WRITE, 29, 29, 1'b0, '0);
      send_cmd(CMD_UNUSED, 0, 0, 1'b0, GEN_ALL_ONES);
      send_cmd(CMD_UNUSED, 31, 0, 1'b1, '0);
      // A blinker that straddles the column wrap.
      send_cmd(tlge_pkg::CMD_WRITE, 0, 29, 1'b1, '0);
      send_cmd(tlge_pkg::CMD_WRITE, 0, 1, 1'b1, '0);
      send_cmd(tlge_pkg::CMD_RUN, 0, 1, 1'b0, '0);
      send_cmd(tlge_pkg::CMD_RUN, 29, 0, 1'b1, 20'd1);
      send_cmd(tlge_pkg::CMD_READ, 1, 0, 1'b0, '0);
      send_cmd(tlge_pkg::CMD_RUN, 0, 29, 1'b0, 20'd2);
      // The longest run leaves the blinker in its other phase.
      send_cmd(tlge_pkg::CMD_RUN, 0, 0, 1'b0, GEN_ALL_ONES);
      send_cmd(tlge_pkg::CMD_READ, 0, 29, 1'b0, '0);
      send_cmd(tlge_pkg::CMD_READ, 29, 0, 1'b0, '0);
   endtask

   // Cells beyond a shrunken grid keep their values and come back when it grows again.
   task automatic test_hidden_cells();
      set_sizes(6'd32, 6'd32);
      send_idle_pct = 17;
      rsp_stall_pct = 17;
      send_cmd(tlge_pkg::CMD_WRITE, 31, 31, 1'b1, '0);
      send_cmd(tlge_pkg::CMD_WRITE, 31, 30, 1'b1, '0);
      send_cmd(tlge_pkg::CMD_WRITE, 30, 31, 1'b1, '0);
      set_sizes(6'd3, 6'd3);
      send_cmd(tlge_pkg::CMD_WRITE, 2, 2, 1'b1, '0);
      send_cmd(tlge_pkg::CMD_RUN, 0, 0, 1'b0, 20'd4);
      send_cmd(tlge_pkg::CMD_READ, 31, 31, 1'b0, '0);
      set_sizes(6'd32, 6'd32);
      send_cmd(tlge_pkg::CMD_READ, 31, 31, 1'b0, '0);
      send_cmd(tlge_pkg::CMD_RUN, 31, 31, 1'b0, 20'd3);
      send_cmd(tlge_pkg::CMD_READ, 30, 30, 1'b0, '0);
   endtask

   // Size registers below, at and above the usable range.
   task automatic test_size_clamping();
      set_sizes(6'd0, 6'd63);
      send_idle_pct = 0;
      rsp_stall_pct = 75;
      run_random_items(50);
      set_sizes(6'd2, 6'd33);
      send_idle_pct = 75;
      rsp_stall_pct = 0;
      run_random_items(50);
      set_sizes(6'd63, 6'd5);
      send_idle_pct = 17;
      rsp_stall_pct = 17;
      run_random_items(50);
      set_sizes(6'd1, 6'd32);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_items(45);
   endtask

   // Random patterns on square and oblong grids under every idling mix.
   task automatic test_random_patterns();
      set_sizes(6'd8, 6'd8);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_items(60);
      set_sizes(6'd3, 6'd3);
      send_idle_pct = 75;
      rsp_stall_pct = 0;
      run_random_items(50);
      set_sizes(6'd13, 6'd7);
      send_idle_pct = 0;
      rsp_stall_pct = 75;
      run_random_items(50);
      set_sizes(6'd32, 6'd32);
      send_idle_pct = 17;
      rsp_stall_pct = 17;
      run_random_items(60);
      set_sizes(6'd5, 6'd12);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_items(50);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.cmd = tlge_pkg::CMD_READ;
      req_bus.row = '0;
      req_bus.col = '0;
      req_bus.cell_in = 1'b0;
      req_bus.generations = '0;
      rsp_bus.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = tlge_pkg::CSR_GRID_ROWS;
      csr_wr_data = '0;
      life_grid = '0;
      rows_reg = tlge_pkg::SIZE_RESET;
      cols_reg = tlge_pkg::SIZE_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_and_edges();
      test_hidden_cells();
      test_size_clamping();
      test_random_patterns();

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_cells.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/tlge_pkg.sv
src/tlge_req_if.sv
src/tlge_rsp_if.sv
src/tlge_row_cell.sv
src/tlge_seq.sv
src/toroidal_life_grid_engine_unit.sv
bench/tb_top.sv
